### src/bse_pkg.sv
package bse_pkg;

  // Default values of the calibration parameters
  localparam int unsigned STREAK_LENGTH_DEF     = 5;
  localparam int unsigned ABSENCE_LEVEL_MV_DEF  = 100;
  localparam int unsigned ABSENCE_MARGIN_MV_DEF = 100;

  // Fixed constants of the estimator
  localparam logic [16:0] SOC_FULL         = 17'd65536;
  localparam logic [15:0] DROP_MV          = 16'd10;
  localparam logic [11:0] UNCAL_PRESENT_MV = 12'd100;
  localparam logic [12:0] MIN_THRESHOLD_MV = 13'd50;
  localparam logic [12:0] THRESHOLD_RESET  = 13'd150;
  localparam logic [15:0] CAP_ONE_Q15      = 16'h8000;
  localparam logic [13:0] SMOOTH_DIVISOR   = 14'd20;
  localparam logic [17:0] PERCENT_SCALE    = 18'd100;

  // Register reset values
  localparam logic [15:0] BSCALE_RESET    = 16'd8192;
  localparam logic [13:0] FULL_RECH_RESET = 14'd4200;
  localparam logic [13:0] FULL_PRIM_RESET = 14'd3600;
  localparam logic [13:0] EMPTY_RESET     = 14'd2000;
  localparam logic [13:0] ENTER_RESET     = 14'd3800;
  localparam logic [13:0] EXIT_RESET      = 14'd3650;
  localparam logic [17:0] SSCALE_RESET    = 18'd16384;
  localparam logic [15:0] CAP_RESET       = 16'd32768;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BATTERY_SCALE  = 3'd0,
    REG_FULL_RECH      = 3'd1,
    REG_FULL_PRIM      = 3'd2,
    REG_EMPTY          = 3'd3,
    REG_RECH_ENTER     = 3'd4,
    REG_RECH_EXIT      = 3'd5,
    REG_SOURCE_SCALE   = 3'd6,
    REG_CAPACITY       = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] battery_scale_q12;
    logic [13:0] full_rechargeable_mv;
    logic [13:0] full_primary_mv;
    logic [13:0] empty_mv;
    logic [13:0] rechargeable_enter_mv;
    logic [13:0] rechargeable_exit_mv;
    logic [17:0] source_scale_q12;
    logic [15:0] capacity_factor_q15;
  } cfg_t;

  // Request to the shared divider: remainder seed, left-aligned dividend bits, divisor and step count
  typedef struct packed {
    logic [13:0] rem_init;
    logic [23:0] bits;
    logic [13:0] divisor;
    logic [4:0]  count;
  } div_req_t;

  typedef struct packed {
    logic [6:0]  battery_percent;
    logic        cell_present;
    logic [15:0] battery_mv;
    logic [15:0] source_mv;
    logic [16:0] smoothed_soc_q16;
    logic        absence_done;
  } result_t;

endpackage

### src/bse_div.sv
module bse_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  bse_pkg::div_req_t  req_i,
  output logic               done_o,
  output logic [23:0]        quot_o
);
  import bse_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [13:0] rem_q, rem_d;
  logic [23:0] bits_q, bits_d;
  logic [23:0] quot_q, quot_d;
  logic [13:0] dvs_q, dvs_d;
  logic [14:0] trial;
  logic [14:0] diff;

  // One restoring step: shift in the next dividend bit, subtract if it fits; a start loads a new request
  always_comb begin
    trial  = {rem_q, bits_q[23]};
    diff   = trial - {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    bits_d = bits_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = req_i.count;
      rem_d  = req_i.rem_init;
      bits_d = req_i.bits;
      quot_d = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      bits_d = {bits_q[22:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = diff[13:0];
        quot_d = {quot_q[22:0], 1'b1};
      end else begin
        rem_d  = trial[13:0];
        quot_d = {quot_q[22:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    bits_q <= bits_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### src/bse_seq.sv
module bse_seq #(
  parameter int unsigned STREAK_LENGTH     = bse_pkg::STREAK_LENGTH_DEF,
  parameter int unsigned ABSENCE_LEVEL_MV  = bse_pkg::ABSENCE_LEVEL_MV_DEF,
  parameter int unsigned ABSENCE_MARGIN_MV = bse_pkg::ABSENCE_MARGIN_MV_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bse_pkg::cfg_t      cfg_i,
  input  logic               start_i,
  input  logic [11:0]        battery_adc_mv_i,
  input  logic [11:0]        calibration_adc_mv_i,
  input  logic [11:0]        source_adc_mv_i,
  output logic               idle_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output bse_pkg::result_t   res_o
);
  import bse_pkg::*;

  localparam logic [7:0]  STREAK_LEN = 8'(STREAK_LENGTH);
  localparam logic [17:0] STREAK_M1  = 18'(STREAK_LENGTH - 1);
  localparam logic [23:0] LEVEL_Q12  = 24'(ABSENCE_LEVEL_MV) << 12;
  localparam logic [12:0] MARGIN     = 13'(ABSENCE_MARGIN_MV);

  typedef enum logic [3:0] {
    S_IDLE, S_VBAT, S_VSRC, S_CLASS, S_DIVSOC, S_SMOOTH, S_DIVSM,
    S_ADJ, S_PCT, S_ACC, S_DIVAB, S_FIN
  } state_e;

  state_e      state_q;
  logic [11:0] bat_q, cal_q, src_q;
  logic [15:0] vbat_q, vsrc_q;
  logic [16:0] raw_q;
  logic [16:0] smoothed_q;
  logic        soc_loaded_q, prev_loaded_q;
  logic [15:0] prev_q;
  logic        mode_q;
  logic [16:0] adj_q;
  logic [6:0]  pct_q;
  logic [23:0] avg_q;
  logic [7:0]  streak_q;
  logic        calib_q;
  logic [12:0] thr_q;

  // Shared multiplier operands and product
  logic [23:0] mul_a;
  logic [17:0] mul_b;
  logic [41:0] prod;
  logic [30:0] rnd_sum;
  logic [15:0] scaled_sat;
  logic [23:0] pct_sum;
  logic [32:0] acc;

  // Classification compares
  logic [15:0] full_rech, full_prim, empty, enter, exitv, full_sel;
  logic        mode_n;
  logic [15:0] cap_clip;

  // Smoothing terms
  logic [16:0] old_soc;
  logic [15:0] prev_v;
  logic [15:0] drop_mv;
  logic        drop;
  logic        rise;
  logic [16:0] rise_diff;

  // Absence update terms
  logic [7:0]  streak_n;
  logic [12:0] thr_n;

  logic        div_start;
  div_req_t    div_req;
  logic        div_done;
  logic [23:0] div_quot;

  bse_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Select multiplier operands by step
  always_comb begin
    cap_clip = (cfg_i.capacity_factor_q15 > CAP_ONE_Q15) ? CAP_ONE_Q15
                                                          : cfg_i.capacity_factor_q15;
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_VBAT: begin
        mul_a = {12'd0, bat_q};
        mul_b = {2'd0, cfg_i.battery_scale_q12};
      end
      S_VSRC: begin
        mul_a = {12'd0, src_q};
        mul_b = cfg_i.source_scale_q12;
      end
      S_ADJ: begin
        mul_a = {7'd0, smoothed_q};
        mul_b = {2'd0, cap_clip};
      end
      S_PCT: begin
        mul_a = {7'd0, adj_q};
        mul_b = PERCENT_SCALE;
      end
      S_ACC: begin
        mul_a = avg_q;
        mul_b = STREAK_M1;
      end
      default: ;
    endcase
    prod       = 42'(mul_a) * 42'(mul_b);
    rnd_sum    = {1'b0, prod[29:0]} + 31'd2048;
    scaled_sat = (|rnd_sum[30:28]) ? 16'hFFFF : rnd_sum[27:12];
    pct_sum    = {1'b0, prod[22:0]} + 24'd32768;
    acc        = {1'b0, prod[31:0]} + {9'd0, cal_q, 12'd0};
  end

  // Voltage to charge classification and hysteresis
  always_comb begin
    full_rech = {2'd0, cfg_i.full_rechargeable_mv};
    full_prim = {2'd0, cfg_i.full_primary_mv};
    empty     = {2'd0, cfg_i.empty_mv};
    enter     = {2'd0, cfg_i.rechargeable_enter_mv};
    exitv     = {2'd0, cfg_i.rechargeable_exit_mv};
    if (vbat_q >= enter) begin
      mode_n = 1'b1;
    end else if (vbat_q <= exitv) begin
      mode_n = 1'b0;
    end else begin
      mode_n = mode_q;
    end
    full_sel = mode_n ? full_rech : full_prim;
  end

  // Smoothing decision and absence streak
  always_comb begin
    old_soc   = soc_loaded_q ? smoothed_q : raw_q;
    prev_v    = prev_loaded_q ? prev_q : vbat_q;
    drop_mv   = prev_v - vbat_q;
    drop      = (prev_v > vbat_q) && (drop_mv > DROP_MV);
    rise      = raw_q > old_soc;
    rise_diff = raw_q - old_soc;
    if (div_quot < LEVEL_Q12) begin
      streak_n = (streak_q == 8'hFF) ? streak_q : streak_q + 8'd1;
    end else begin
      streak_n = '0;
    end
    thr_n = {1'b0, div_quot[23:12]} + MARGIN;
    if (thr_n < MIN_THRESHOLD_MV) begin
      thr_n = MIN_THRESHOLD_MV;
    end
  end

  // Divider requests
  always_comb begin
    div_start = 1'b0;
    div_req   = '0;
    case (state_q)
      S_CLASS: begin
        div_req.rem_init = vbat_q[13:0] - cfg_i.empty_mv;
        div_req.bits     = '0;
        div_req.divisor  = full_sel[13:0] - cfg_i.empty_mv;
        div_req.count    = 5'd16;
        div_start        = (vbat_q < full_rech) && (vbat_q > empty) && (vbat_q < full_sel);
      end
      S_SMOOTH: begin
        div_req.rem_init = '0;
        div_req.bits     = {rise_diff, 7'd0};
        div_req.divisor  = SMOOTH_DIVISOR;
        div_req.count    = 5'd17;
        div_start        = !drop && rise;
      end
      S_ACC: begin
        div_req.rem_init = {5'd0, acc[32:24]};
        div_req.bits     = acc[23:0];
        div_req.divisor  = {6'd0, STREAK_LEN};
        div_req.count    = 5'd24;
        div_start        = 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      smoothed_q    <= '0;
      soc_loaded_q  <= 1'b0;
      prev_q        <= '0;
      prev_loaded_q <= 1'b0;
      mode_q        <= 1'b0;
      avg_q         <= '0;
      streak_q      <= '0;
      calib_q       <= 1'b0;
      thr_q         <= THRESHOLD_RESET;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_VBAT;
          end
        end
        S_VBAT: begin
          state_q <= S_VSRC;
        end
        S_VSRC: begin
          state_q <= S_CLASS;
        end
        S_CLASS: begin
          if (vbat_q >= full_rech || vbat_q <= empty) begin
            state_q <= S_SMOOTH;
          end else begin
            mode_q <= mode_n;
            state_q <= div_start ? S_DIVSOC : S_SMOOTH;
          end
        end
        S_DIVSOC: begin
          if (div_done) begin
            state_q <= S_SMOOTH;
          end
        end
        S_SMOOTH: begin
          soc_loaded_q  <= 1'b1;
          prev_loaded_q <= 1'b1;
          prev_q        <= vbat_q;
          if (div_start) begin
            smoothed_q <= old_soc;
            state_q    <= S_DIVSM;
          end else begin
            smoothed_q <= raw_q;
            state_q    <= S_ADJ;
          end
        end
        S_DIVSM: begin
          if (div_done) begin
            smoothed_q <= smoothed_q + div_quot[16:0];
            state_q    <= S_ADJ;
          end
        end
        S_ADJ: begin
          state_q <= S_PCT;
        end
        S_PCT: begin
          state_q <= calib_q ? S_FIN : S_ACC;
        end
        S_ACC: begin
          state_q <= S_DIVAB;
        end
        S_DIVAB: begin
          if (div_done) begin
            avg_q    <= div_quot;
            streak_q <= streak_n;
            if (streak_n >= STREAK_LEN) begin
              thr_q   <= thr_n;
              calib_q <= 1'b1;
            end
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers of the item in flight
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      bat_q <= battery_adc_mv_i;
      cal_q <= calibration_adc_mv_i;
      src_q <= source_adc_mv_i;
    end
    if (state_q == S_VBAT) begin
      vbat_q <= scaled_sat;
    end
    if (state_q == S_VSRC) begin
      vsrc_q <= scaled_sat;
    end
    if (state_q == S_CLASS) begin
      if (vbat_q >= full_rech) begin
        raw_q <= SOC_FULL;
      end else if (vbat_q <= empty) begin
        raw_q <= '0;
      end else begin
        raw_q <= SOC_FULL;
      end
    end
    if (state_q == S_DIVSOC && div_done) begin
      raw_q <= {1'b0, div_quot[15:0]};
    end
    if (state_q == S_ADJ) begin
      adj_q <= prod[31:15];
    end
    if (state_q == S_PCT) begin
      pct_q <= pct_sum[22:16];
    end
  end

  // Build the result word
  logic present;
  always_comb begin
    present = calib_q ? ({1'b0, bat_q} > thr_q) : (bat_q > UNCAL_PRESENT_MV);
    res_o.battery_percent  = present ? pct_q : '0;
    res_o.cell_present     = present;
    res_o.battery_mv       = vbat_q;
    res_o.source_mv        = vsrc_q;
    res_o.smoothed_soc_q16 = present ? smoothed_q : '0;
    res_o.absence_done     = calib_q;
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_FIN);

endmodule

### src/battery_soc_estimator_top.sv
// Battery state-of-charge estimator.
// Input stream: one word per set of ADC readings (battery node, calibration
// node, power source node, millivolts). Output stream: one word per input word
// with percent, presence, scaled voltages, smoothed Q16 charge and calibration
// status. A separate write channel loads the eight setup registers; it is
// always ready. The user must write it only while the block is idle; the block
// itself does not enforce this. A word runs through the sequencer steps plus
// one divider pass for each division it needs: the voltage-to-charge ratio
// (16 steps), rising smoothing (17 steps) and the absence average while
// uncalibrated (24 steps). One bit-serial divider and one multiplier are shared
// by the steps under the sequencer, and the block takes one word at a time:
// s_axis_tready is high only while it is idle, so a new word is taken only after
// the last one has left the sequencer. The result sits in an output register, so
// the next word is accepted while a result waits; if the receiver stalls longer,
// the sequencer holds its finished result until the output register frees.
// Reset clears the sequencer, the smoothing and calibration state and loads the
// register defaults; the output register comes up empty.
module battery_soc_estimator_top #(
  parameter int unsigned STREAK_LENGTH     = bse_pkg::STREAK_LENGTH_DEF,
  parameter int unsigned ABSENCE_LEVEL_MV  = bse_pkg::ABSENCE_LEVEL_MV_DEF,
  parameter int unsigned ABSENCE_MARGIN_MV = bse_pkg::ABSENCE_MARGIN_MV_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bse_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bse_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [11:0] battery_adc_mv, [23:12] calibration_adc_mv, [35:24] source_adc_mv
  input  logic [39:0]                     s_axis_tdata,
  // Output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [6:0] battery_percent, [22:7] battery_mv, [38:23] source_mv,
  // [55:39] smoothed_soc_q16
  output logic [55:0]                     m_axis_tdata,
  // [0] cell_present, [1] absence_done
  output logic [1:0]                      m_axis_tuser
);
  import bse_pkg::*;

  cfg_t    cfg_q;
  logic    idle;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  logic    out_valid_q;
  result_t out_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.battery_scale_q12     <= BSCALE_RESET;
      cfg_q.full_rechargeable_mv  <= FULL_RECH_RESET;
      cfg_q.full_primary_mv       <= FULL_PRIM_RESET;
      cfg_q.empty_mv              <= EMPTY_RESET;
      cfg_q.rechargeable_enter_mv <= ENTER_RESET;
      cfg_q.rechargeable_exit_mv  <= EXIT_RESET;
      cfg_q.source_scale_q12      <= SSCALE_RESET;
      cfg_q.capacity_factor_q15   <= CAP_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_BATTERY_SCALE: cfg_q.battery_scale_q12     <= cfg_data_i[15:0];
        REG_FULL_RECH:     cfg_q.full_rechargeable_mv  <= cfg_data_i[13:0];
        REG_FULL_PRIM:     cfg_q.full_primary_mv       <= cfg_data_i[13:0];
        REG_EMPTY:         cfg_q.empty_mv              <= cfg_data_i[13:0];
        REG_RECH_ENTER:    cfg_q.rechargeable_enter_mv <= cfg_data_i[13:0];
        REG_RECH_EXIT:     cfg_q.rechargeable_exit_mv  <= cfg_data_i[13:0];
        REG_SOURCE_SCALE:  cfg_q.source_scale_q12      <= cfg_data_i[17:0];
        REG_CAPACITY:      cfg_q.capacity_factor_q15   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = idle;

  bse_seq #(
    .STREAK_LENGTH     (STREAK_LENGTH),
    .ABSENCE_LEVEL_MV  (ABSENCE_LEVEL_MV),
    .ABSENCE_MARGIN_MV (ABSENCE_MARGIN_MV)
  ) u_seq (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg_q),
    .start_i              (s_axis_tvalid),
    .battery_adc_mv_i     (s_axis_tdata[11:0]),
    .calibration_adc_mv_i (s_axis_tdata[23:12]),
    .source_adc_mv_i      (s_axis_tdata[35:24]),
    .idle_o               (idle),
    .res_valid_o          (res_valid),
    .res_ready_i          (res_ready),
    .res_o                (res)
  );

  // Output register: load a finished word when the slot is free or draining
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.smoothed_soc_q16, out_q.source_mv, out_q.battery_mv,
                          out_q.battery_percent};
  assign m_axis_tuser  = {out_q.absence_done, out_q.cell_present};

endmodule

### src/bse_checker.sv
module bse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled output word changed");

  // Drop ready for the word after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  // Keep percent and charge in range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[6:0] <= 7'd100) && (m_axis_tdata[55:39] <= 17'd65536))
    else $error("percent or charge out of range");

  // Report zero charge for an absent battery
  a_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      (m_axis_tdata[6:0] == 7'd0) && (m_axis_tdata[55:39] == 17'd0))
    else $error("absent battery reports charge");

endmodule

bind battery_soc_estimator_top bse_checker u_bse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
